/* hdl/per_client_window_rate_limiter_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the per-client window rate limiter
// Shared property forms used by the checker of the block.
// ----------------------------------------------------------------------------
`ifndef PER_CLIENT_WINDOW_RATE_LIMITER_ASSERT_SVH
`define PER_CLIENT_WINDOW_RATE_LIMITER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCWRL_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pcwrl assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PCWRL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pcwrl assertion failed");

`endif

/* hdl/pcwrl_pkg.sv */
// ----------------------------------------------------------------------------
// Per-client window rate limiter package
// Types, codes and constants shared by the limiter, its cells and checker.
// ----------------------------------------------------------------------------
package pcwrl_pkg;

  localparam int DATA_W = 32;
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int CFG_ADDR_W = 1;

  localparam logic [DATA_W-1:0] LIMIT_RESET = 32'd100;
  localparam logic [DATA_W-1:0] WINDOW_RESET = 32'd60;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LIMIT  = 1'b0,
    CFG_WINDOW = 1'b1
  } pcwrl_cfg_e;

  typedef enum logic [1:0] {
    OP_CHECK    = 2'd0,
    OP_REGISTER = 2'd1,
    OP_CLEAR    = 2'd2
  } pcwrl_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_GATHER
  } pcwrl_state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [DATA_W-1:0] client_addr;
    logic [DATA_W-1:0] now_seconds;
  } pcwrl_req_t;

  typedef struct packed {
    logic              allowed;
    logic [DATA_W-1:0] request_count;
    logic              table_full;
  } pcwrl_rsp_t;

  typedef struct packed {
    logic              probe;
    logic              update;
    logic              clear;
    logic              sel;
    logic              do_reg;
    logic              alloc;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] now;
    logic [DATA_W-1:0] window;
  } pcwrl_ctrl_t;

endpackage

/* hdl/pcwrl_cell.sv */
// ----------------------------------------------------------------------------
// Rate limiter table cell
// Holds one client entry, matches it against the broadcast request, applies
// the window check and count update locally and passes the free-slot chain.
// ----------------------------------------------------------------------------
module pcwrl_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pcwrl_pkg::pcwrl_ctrl_t          ctrl_i,
  input  logic                            free_below_i,
  output logic                            free_seen_o,
  output logic                            match_o,
  output logic [pcwrl_pkg::DATA_W-1:0]    count_o
);

  logic                         valid_q;
  logic                         match_q;
  logic                         sel_q;
  logic                         expired_q;
  logic [pcwrl_pkg::DATA_W-1:0] key_q;
  logic [pcwrl_pkg::DATA_W-1:0] count_q;
  logic [pcwrl_pkg::DATA_W-1:0] start_q;
  logic                         chosen;
  logic [pcwrl_pkg::DATA_W-1:0] base_count;
  logic [pcwrl_pkg::DATA_W-1:0] bumped;

  assign chosen      = ctrl_i.alloc & ~valid_q & ~free_below_i;
  assign free_seen_o = free_below_i | ~valid_q;
  assign match_o     = match_q;
  assign count_o     = sel_q ? count_q : '0;

  assign base_count = expired_q ? '0 : count_q;
  assign bumped     = (base_count == '1) ? base_count
                                         : base_count + pcwrl_pkg::DATA_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      if (ctrl_i.probe) begin
        match_q <= valid_q && (key_q == ctrl_i.key);
      end
      if (ctrl_i.update) begin
        if (ctrl_i.clear) begin
          valid_q <= 1'b0;
        end else if (chosen) begin
          valid_q <= 1'b1;
        end
        sel_q <= ctrl_i.sel & (match_q | chosen);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.probe) begin
      expired_q <= (ctrl_i.now - start_q) >= ctrl_i.window;
    end
    if (ctrl_i.update && ctrl_i.sel) begin
      if (match_q) begin
        count_q <= ctrl_i.do_reg ? bumped : base_count;
        if (expired_q) begin
          start_q <= ctrl_i.now;
        end
      end else if (chosen) begin
        key_q   <= ctrl_i.key;
        count_q <= pcwrl_pkg::DATA_W'(1);
        start_q <= ctrl_i.now;
      end
    end
  end

endmodule

/* hdl/per_client_window_rate_limiter.sv */
// ----------------------------------------------------------------------------
// Per-client window rate limiter
// A row of client cells that count requests per fixed time window.
// ----------------------------------------------------------------------------
// Requests enter on the in_valid_i / in_ready_o channel with an opcode, a
// client address and the current time; each request yields exactly one
// response on out_valid_o / out_ready_i. A request is registered when taken,
// every cell compares its key and window in the match state, the matching or
// newly allocated cell updates itself in the update state, and the gather
// state loads the selected count into the output register once that is free.
// The lowest free cell is found by a free-slot chain that runs through the
// row of cells. A new request is taken once the previous one has been
// gathered, so a held response in the output register does not block the
// next request until its gather step. Reset empties the table and loads a
// limit of 100 requests and a window of 60 seconds; no clearing pass is
// needed. The two configuration registers are written through cfg_we_i
// while no request is in flight; the user, not the block, must ensure this.
// ----------------------------------------------------------------------------
module per_client_window_rate_limiter #(
  parameter int TABLE_ENTRIES = pcwrl_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [pcwrl_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [pcwrl_pkg::DATA_W-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pcwrl_pkg::pcwrl_req_t             in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pcwrl_pkg::pcwrl_rsp_t             out_data_o
);

  pcwrl_pkg::pcwrl_state_e      state_q, state_d;
  pcwrl_pkg::pcwrl_req_t        req_q;
  pcwrl_pkg::pcwrl_rsp_t        out_q, rsp;
  pcwrl_pkg::pcwrl_ctrl_t       ctrl;
  logic                         out_valid_q;
  logic [pcwrl_pkg::DATA_W-1:0] limit_q;
  logic [pcwrl_pkg::DATA_W-1:0] window_q;
  logic                         hit_q;
  logic                         full_q;
  logic                         hit;
  logic                         is_check;
  logic                         is_reg;
  logic                         load_out;
  logic [TABLE_ENTRIES-1:0]     match_vec;
  logic [TABLE_ENTRIES:0]       free_chain;
  logic [TABLE_ENTRIES-1:0][pcwrl_pkg::DATA_W-1:0] count_vec;
  logic [pcwrl_pkg::DATA_W-1:0] count_or;

  assign is_check = (req_q.opcode == pcwrl_pkg::OP_CHECK);
  assign is_reg   = (req_q.opcode == pcwrl_pkg::OP_REGISTER);
  assign hit      = |match_vec;

  always_comb begin
    ctrl.probe  = (state_q == pcwrl_pkg::ST_MATCH);
    ctrl.update = (state_q == pcwrl_pkg::ST_UPDATE);
    ctrl.clear  = (req_q.opcode == pcwrl_pkg::OP_CLEAR);
    ctrl.sel    = is_check | is_reg;
    ctrl.do_reg = is_reg;
    ctrl.alloc  = (state_q == pcwrl_pkg::ST_UPDATE) & is_reg & ~hit;
    ctrl.key    = req_q.client_addr;
    ctrl.now    = req_q.now_seconds;
    ctrl.window = window_q;
  end

  assign free_chain[0] = 1'b0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    pcwrl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .free_below_i (free_chain[i]),
      .free_seen_o  (free_chain[i+1]),
      .match_o      (match_vec[i]),
      .count_o      (count_vec[i])
    );
  end

  always_comb begin
    count_or = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      count_or = count_or | count_vec[i];
    end
  end

  always_comb begin
    rsp = '0;
    if (is_check) begin
      rsp.allowed       = hit_q ? (count_or < limit_q) : 1'b1;
      rsp.request_count = hit_q ? count_or : '0;
    end else if (is_reg) begin
      if (full_q) begin
        rsp.allowed    = 1'b1;
        rsp.table_full = 1'b1;
      end else begin
        rsp.allowed       = count_or < limit_q;
        rsp.request_count = count_or;
      end
    end
  end

  assign load_out = (state_q == pcwrl_pkg::ST_GATHER) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      pcwrl_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = pcwrl_pkg::ST_MATCH;
        end
      end
      pcwrl_pkg::ST_MATCH: begin
        state_d = pcwrl_pkg::ST_UPDATE;
      end
      pcwrl_pkg::ST_UPDATE: begin
        state_d = pcwrl_pkg::ST_GATHER;
      end
      pcwrl_pkg::ST_GATHER: begin
        if (load_out) begin
          state_d = pcwrl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcwrl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcwrl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      limit_q     <= pcwrl_pkg::LIMIT_RESET;
      window_q    <= pcwrl_pkg::WINDOW_RESET;
      hit_q       <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          pcwrl_pkg::CFG_LIMIT:  limit_q  <= cfg_wdata_i;
          pcwrl_pkg::CFG_WINDOW: window_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == pcwrl_pkg::ST_UPDATE) begin
        hit_q  <= hit;
        full_q <= ctrl.alloc & ~free_chain[TABLE_ENTRIES];
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_data_i;
    end
    if (load_out) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* hdl/pcwrl_checker.sv */
// ----------------------------------------------------------------------------
// Rate limiter port checker
// Watches the request and response channels of the limiter over time.
// ----------------------------------------------------------------------------
`include "per_client_window_rate_limiter_assert.svh"

module pcwrl_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input pcwrl_pkg::pcwrl_rsp_t out_data_o
);

  `PCWRL_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `PCWRL_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `PCWRL_ASSERT_NEXT(a_busy_two_after, $past(in_valid_i && in_ready_o), !in_ready_o)
  `PCWRL_ASSERT_SAME(a_full_form, out_valid_o && out_data_o.table_full, out_data_o.allowed && (out_data_o.request_count == '0))

endmodule

bind per_client_window_rate_limiter pcwrl_checker u_pcwrl_checker (.*);

/* tb/sv/per_client_window_rate_limiter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the per-client window rate limiter
// Drives check, register, clear and unused requests through the valid/ready
// channel under several limit and window settings, predicts every response
// with a behavioral copy of the client table and compares each response
// field by field, with random idling on both sides and long receiver stalls.
// ----------------------------------------------------------------------------
module per_client_window_rate_limiter_tb;

  localparam int TABLE_SIZE = pcwrl_pkg::TABLE_ENTRIES_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 8;
  localparam int RX_STALL_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;

  logic                             clk_i;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  logic [pcwrl_pkg::CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [pcwrl_pkg::DATA_W-1:0]     cfg_wdata_i = '0;
  logic                             in_valid_i = 1'b0;
  logic                             in_ready_o;
  pcwrl_pkg::pcwrl_req_t            in_data_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i = 1'b0;
  pcwrl_pkg::pcwrl_rsp_t            out_data_o;

  logic                         slot_used [TABLE_SIZE];
  logic [pcwrl_pkg::DATA_W-1:0] slot_key [TABLE_SIZE];
  logic [pcwrl_pkg::DATA_W-1:0] slot_count [TABLE_SIZE];
  logic [pcwrl_pkg::DATA_W-1:0] slot_start [TABLE_SIZE];
  logic [pcwrl_pkg::DATA_W-1:0] limit_cfg;
  logic [pcwrl_pkg::DATA_W-1:0] window_cfg;

  pcwrl_pkg::pcwrl_rsp_t expected_rsp_q [$];
  pcwrl_pkg::pcwrl_rsp_t checked_rsp;
  int         error_count = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         stall_kicks = 0;
  int         stall_seen = 0;
  int         stall_left = 0;
  int         quiet_cycles = 0;

  per_client_window_rate_limiter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void reset_table_model();
    limit_cfg = pcwrl_pkg::LIMIT_RESET;
    window_cfg = pcwrl_pkg::WINDOW_RESET;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_count[i] = '0;
      slot_start[i] = '0;
    end
  endfunction

  function automatic void restart_window(input int slot,
                                         input logic [pcwrl_pkg::DATA_W-1:0] now);
    logic [pcwrl_pkg::DATA_W-1:0] elapsed;
    elapsed = now - slot_start[slot];
    if (elapsed >= window_cfg) begin
      slot_count[slot] = '0;
      slot_start[slot] = now;
    end
  endfunction

  function automatic pcwrl_pkg::pcwrl_rsp_t predict_limiter(input pcwrl_pkg::pcwrl_req_t req);
    pcwrl_pkg::pcwrl_rsp_t rsp;
    int hit;
    int free_slot;
    int slot;
    rsp = '0;
    hit = -1;
    free_slot = -1;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == req.client_addr) hit = i;
      if (!slot_used[i]) free_slot = i;
    end
    if (req.opcode == pcwrl_pkg::OP_CHECK) begin
      if (hit < 0) begin
        rsp.allowed = 1'b1;
      end else begin
        restart_window(hit, req.now_seconds);
        rsp.request_count = slot_count[hit];
        rsp.allowed = slot_count[hit] < limit_cfg;
      end
    end else if (req.opcode == pcwrl_pkg::OP_REGISTER) begin
      slot = -1;
      if (hit >= 0) begin
        restart_window(hit, req.now_seconds);
        slot = hit;
      end else if (free_slot >= 0) begin
        slot = free_slot;
        slot_used[slot] = 1'b1;
        slot_key[slot] = req.client_addr;
        slot_count[slot] = '0;
        slot_start[slot] = req.now_seconds;
      end
      if (slot < 0) begin
        rsp.allowed = 1'b1;
        rsp.table_full = 1'b1;
      end else begin
        if (slot_count[slot] != '1) slot_count[slot] = slot_count[slot] + 1'b1;
        rsp.request_count = slot_count[slot];
        rsp.allowed = slot_count[slot] < limit_cfg;
      end
    end else if (req.opcode == pcwrl_pkg::OP_CLEAR) begin
      for (int i = 0; i < TABLE_SIZE; i++) slot_used[i] = 1'b0;
    end
    return rsp;
  endfunction

  task automatic send_request(input logic [1:0] op,
                              input logic [pcwrl_pkg::DATA_W-1:0] addr,
                              input logic [pcwrl_pkg::DATA_W-1:0] now);
    pcwrl_pkg::pcwrl_req_t req;
    req.opcode = op;
    req.client_addr = addr;
    req.now_seconds = now;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_rsp_q.push_back(predict_limiter(req));
  endtask

  task automatic wait_for_responses(input int settle);
    in_valid_i <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_cfg(input pcwrl_pkg::pcwrl_cfg_e idx,
                           input logic [pcwrl_pkg::DATA_W-1:0] value);
    wait_for_responses(SETTLE_CYCLES);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == pcwrl_pkg::CFG_LIMIT) limit_cfg = value;
    else window_cfg = value;
  endtask

  task automatic set_idle(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  // Mostly check and register requests on a small set of clients with a
  // slowly moving clock, mixed with clears, unused opcodes and strangers.
  task automatic run_traffic(input int n_items, input int pool_size, input int stall_at,
                             input int pause_at,
                             input logic [pcwrl_pkg::DATA_W-1:0] start_time);
    logic [pcwrl_pkg::DATA_W-1:0] pool [16];
    logic [pcwrl_pkg::DATA_W-1:0] cur_time;
    int pick;
    int step;
    cur_time = start_time;
    for (int i = 0; i < pool_size; i++) pool[i] = $urandom;
    for (int n = 0; n < n_items; n++) begin
      if (n == stall_at) stall_kicks++;
      if (n == pause_at) wait_for_responses(0);
      pick = $urandom_range(99);
      if (pick < 2) begin
        send_request(pcwrl_pkg::OP_CLEAR, $urandom, $urandom);
      end else if (pick < 4) begin
        send_request(OP_UNUSED, $urandom, $urandom);
      end else if (pick < 7) begin
        send_request(2'($urandom_range(1)), $urandom, $urandom);
      end else if (pick < 40) begin
        send_request(pcwrl_pkg::OP_CHECK, pool[$urandom_range(pool_size - 1)], cur_time);
      end else begin
        send_request(pcwrl_pkg::OP_REGISTER, pool[$urandom_range(pool_size - 1)], cur_time);
      end
      step = $urandom_range(99);
      if (step < 3) cur_time = $urandom;
      else if (step < 6) cur_time = cur_time - $urandom_range(3, 1);
      else cur_time = cur_time + $urandom_range(2);
    end
  endtask

  task automatic test_directed();
    send_request(pcwrl_pkg::OP_CHECK, 32'h0000_0000, 32'h0000_0000);
    send_request(pcwrl_pkg::OP_REGISTER, 32'h0000_0000, 32'h0000_0000);
    send_request(pcwrl_pkg::OP_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(pcwrl_pkg::OP_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(pcwrl_pkg::OP_REGISTER, 32'h0000_0000, 32'd59);
    send_request(pcwrl_pkg::OP_CHECK, 32'h0000_0000, 32'd60);
    send_request(pcwrl_pkg::OP_REGISTER, 32'hFFFF_FFFF, 32'd58);
    send_request(pcwrl_pkg::OP_REGISTER, 32'hFFFF_FFFF, 32'd59);
    send_request(pcwrl_pkg::OP_CHECK, 32'h0000_0000, 32'd10);
    send_request(OP_UNUSED, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    send_request(OP_UNUSED, 32'h0000_0000, 32'h0000_0000);
    send_request(pcwrl_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(pcwrl_pkg::OP_CHECK, 32'h0000_0000, 32'd61);
    send_request(pcwrl_pkg::OP_REGISTER, 32'h1234_5678, 32'd100);
  endtask

  task automatic test_low_limit();
    write_cfg(pcwrl_pkg::CFG_LIMIT, 32'd2);
    repeat (3) send_request(pcwrl_pkg::OP_REGISTER, 32'hC0A8_0001, 32'd5);
    send_request(pcwrl_pkg::OP_CHECK, 32'hC0A8_0001, 32'd6);
    send_request(pcwrl_pkg::OP_CHECK, 32'h1234_5678, 32'd101);
  endtask

  task automatic test_table_full();
    logic [23:0] prefix;
    logic [pcwrl_pkg::DATA_W-1:0] now;
    prefix = 24'($urandom);
    now = $urandom;
    send_request(pcwrl_pkg::OP_CLEAR, $urandom, now);
    for (int i = 0; i < TABLE_SIZE; i++) begin
      send_request(pcwrl_pkg::OP_REGISTER, {prefix, i[7:0]}, now + i);
    end
    for (int k = 0; k < 3; k++) begin
      send_request(pcwrl_pkg::OP_REGISTER, {prefix, 8'hC0 + k[7:0]}, now + 70);
    end
    send_request(pcwrl_pkg::OP_REGISTER, {prefix, 8'd5}, now + 71);
    send_request(pcwrl_pkg::OP_CHECK, {prefix, 8'hD0}, now + 72);
    send_request(pcwrl_pkg::OP_CLEAR, {prefix, 8'd0}, now + 73);
    send_request(pcwrl_pkg::OP_REGISTER, {prefix, 8'hC0}, now + 74);
  endtask

  task automatic test_zero_settings();
    write_cfg(pcwrl_pkg::CFG_LIMIT, 32'h0000_0000);
    write_cfg(pcwrl_pkg::CFG_WINDOW, 32'h0000_0000);
    run_traffic(100, 6, -1, -1, $urandom);
  endtask

  task automatic test_max_settings();
    logic [pcwrl_pkg::DATA_W-1:0] addr;
    logic [pcwrl_pkg::DATA_W-1:0] now;
    write_cfg(pcwrl_pkg::CFG_LIMIT, 32'hFFFF_FFFF);
    write_cfg(pcwrl_pkg::CFG_WINDOW, 32'hFFFF_FFFF);
    addr = $urandom;
    now = $urandom;
    send_request(pcwrl_pkg::OP_REGISTER, addr, now);
    send_request(pcwrl_pkg::OP_REGISTER, addr, now + 5);
    send_request(pcwrl_pkg::OP_REGISTER, addr, now - 1);
    run_traffic(150, 8, -1, -1, $urandom);
  endtask

  task automatic test_short_window();
    write_cfg(pcwrl_pkg::CFG_LIMIT, 32'd3);
    write_cfg(pcwrl_pkg::CFG_WINDOW, 32'd5);
    run_traffic(350, 10, -1, 175, $urandom);
  endtask

  task automatic test_backpressure();
    write_cfg(pcwrl_pkg::CFG_LIMIT, 32'd1);
    write_cfg(pcwrl_pkg::CFG_WINDOW, 32'd2);
    run_traffic(400, 12, 100, 300, 32'hFFFF_FF00);
  endtask

  task automatic report_field(input string field,
                              input logic [pcwrl_pkg::DATA_W-1:0] exp_val,
                              input logic [pcwrl_pkg::DATA_W-1:0] act_val);
    if (error_count < MAX_REPORTS) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, exp_val,
               act_val);
    end
    error_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp_q.size() == 0) begin
        report_field("unexpected response", '0, out_data_o.request_count);
      end else begin
        checked_rsp = expected_rsp_q.pop_front();
        if (out_data_o.allowed !== checked_rsp.allowed) begin
          report_field("allowed", pcwrl_pkg::DATA_W'(checked_rsp.allowed),
                       pcwrl_pkg::DATA_W'(out_data_o.allowed));
        end
        if (out_data_o.request_count !== checked_rsp.request_count) begin
          report_field("request_count", checked_rsp.request_count, out_data_o.request_count);
        end
        if (out_data_o.table_full !== checked_rsp.table_full) begin
          report_field("table_full", pcwrl_pkg::DATA_W'(checked_rsp.table_full),
                       pcwrl_pkg::DATA_W'(out_data_o.table_full));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_kicks != stall_seen) begin
      stall_seen = stall_kicks;
      stall_left = RX_STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    reset_table_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idle(8, 65);
    test_directed();
    test_low_limit();
    test_table_full();
    test_zero_settings();
    set_idle(65, 8);
    test_max_settings();
    test_short_window();
    set_idle(0, 0);
    test_backpressure();
    wait_for_responses(SETTLE_CYCLES * 2);
    if (error_count == 0 && expected_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
